/* sv/kdhr_pkg.sv */
package kdhr_pkg;

	// Key phases, in the order reported on the result stream.
	typedef enum logic [1:0] {
		PH_RELEASED     = 2'd0,
		PH_PRESS_PEND   = 2'd1,
		PH_PRESSED      = 2'd2,
		PH_RELEASE_PEND = 2'd3
	} phase_t;

	localparam int ELAPSED_W = 17;
	localparam int FLAG_W    = 6;
	localparam int STEP_W    = 8;
	localparam int TIME_W    = 15;
	localparam int CFG_IDX_W = 8;

	// Flag bits, from bit 0 up.
	localparam logic [FLAG_W-1:0] FL_PRESS_IN  = 6'h01;
	localparam logic [FLAG_W-1:0] FL_PRESS     = 6'h02;
	localparam logic [FLAG_W-1:0] FL_HOLD_IN   = 6'h04;
	localparam logic [FLAG_W-1:0] FL_HOLD      = 6'h08;
	localparam logic [FLAG_W-1:0] FL_REPEAT_IN = 6'h10;
	localparam logic [FLAG_W-1:0] FL_REPEAT    = 6'h20;
	localparam logic [FLAG_W-1:0] FL_INSIDE    = 6'h15;

	// Action codes carried in tuser.
	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_STEP   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ENSURE_TIME = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_TIME = 8'd3;

	// Reset values of the configuration registers.
	localparam logic [STEP_W-1:0] RST_TICK_STEP   = 8'd10;
	localparam logic [TIME_W-1:0] RST_ENSURE_TIME = 15'd20;
	localparam logic [TIME_W-1:0] RST_HOLD_TIME   = 15'd1000;
	localparam logic [TIME_W-1:0] RST_REPEAT_TIME = 15'd200;

	typedef struct packed {
		phase_t                phase;
		logic [ELAPSED_W-1:0]  elapsed;
		logic [FLAG_W-1:0]     flags;
	} key_state_t;

	typedef struct packed {
		logic [STEP_W-1:0] tick_step;
		logic [TIME_W-1:0] ensure_time;
		logic [TIME_W-1:0] hold_time;
		logic [TIME_W-1:0] repeat_time;
	} key_cfg_t;

endpackage

/* sv/kdhr_step.sv */
module kdhr_step (
	input  kdhr_pkg::key_state_t            cur,
	input  kdhr_pkg::key_cfg_t              cfg,
	input  logic                            action,
	input  logic                            key_level,
	input  logic [kdhr_pkg::FLAG_W-1:0]     query_mask,
	output kdhr_pkg::key_state_t            nxt,
	output logic                            query_true
);

	logic [kdhr_pkg::ELAPSED_W:0]   sum;
	logic [kdhr_pkg::ELAPSED_W-1:0] adv;
	logic [kdhr_pkg::TIME_W:0]      hold_rep;
	logic                           ensure_hit;
	logic                           hold_hit;
	logic                           repeat_hit;

	// Saturating timer advance and the thresholds it is compared with.
	always_comb begin
		sum        = {1'b0, cur.elapsed} + {{(kdhr_pkg::ELAPSED_W + 1 - kdhr_pkg::STEP_W){1'b0}},
			cfg.tick_step};
		adv        = sum[kdhr_pkg::ELAPSED_W] ? '1 : sum[kdhr_pkg::ELAPSED_W-1:0];
		hold_rep   = {1'b0, cfg.hold_time} + {1'b0, cfg.repeat_time};
		ensure_hit = adv >= {2'b00, cfg.ensure_time};
		hold_hit   = adv >= {2'b00, cfg.hold_time};
		repeat_hit = adv >= {1'b0, hold_rep};
	end

	// Next state for a tick or a query.
	always_comb begin
		nxt        = cur;
		query_true = 1'b0;
		if (action == kdhr_pkg::ACT_QUERY) begin
			query_true = (cur.flags & query_mask) == query_mask;
			nxt.flags  = cur.flags & ~(query_mask & ~kdhr_pkg::FL_INSIDE);
		end else begin
			case (cur.phase)
				kdhr_pkg::PH_RELEASED: begin
					if (key_level) begin
						nxt.elapsed = '0;
						nxt.flags   = '0;
						nxt.phase   = kdhr_pkg::PH_PRESS_PEND;
					end
				end
				kdhr_pkg::PH_PRESS_PEND: begin
					nxt.elapsed = adv;
					if (ensure_hit) begin
						if (key_level) begin
							nxt.flags = cur.flags | kdhr_pkg::FL_PRESS_IN | kdhr_pkg::FL_PRESS;
							nxt.phase = kdhr_pkg::PH_PRESSED;
						end else begin
							nxt.phase = kdhr_pkg::PH_RELEASED;
						end
					end
				end
				kdhr_pkg::PH_PRESSED: begin
					if (!key_level) begin
						nxt.elapsed = '0;
						nxt.phase   = kdhr_pkg::PH_RELEASE_PEND;
					end else begin
						nxt.elapsed = adv;
						if (hold_hit) begin
							if ((cur.flags & kdhr_pkg::FL_HOLD_IN) == '0) begin
								nxt.flags = cur.flags | kdhr_pkg::FL_HOLD_IN | kdhr_pkg::FL_HOLD;
							end else if (repeat_hit) begin
								nxt.elapsed = adv - {2'b00, cfg.repeat_time};
								nxt.flags   = cur.flags | kdhr_pkg::FL_REPEAT_IN
									| kdhr_pkg::FL_REPEAT;
							end
						end
					end
				end
				kdhr_pkg::PH_RELEASE_PEND: begin
					nxt.elapsed = adv;
					if (ensure_hit) begin
						if (!key_level) begin
							nxt.phase = kdhr_pkg::PH_RELEASED;
							nxt.flags = cur.flags & ~kdhr_pkg::FL_INSIDE;
						end else begin
							nxt.phase = kdhr_pkg::PH_PRESSED;
						end
					end
				end
				default: begin
					nxt = cur;
				end
			endcase
		end
	end

endmodule

/* sv/key_debounce_hold_repeat_core.sv */
// Push-key qualifier: debounce, hold and auto-repeat events with queryable flags.
// An input transfer passes the input register and then the result register.
// One item per cycle unless the result stream stalls; key state updates per item.
// Reset (arst_n low, asynchronous): key released, timer and flags cleared,
// configuration registers back to their defaults, both stream stages empty.
module key_debounce_hold_repeat_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input stream.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,  // [0] key_level, [6:1] query_mask, [7] zero
	input  logic                              s_tuser,  // [0] action
	// Result stream.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [15:0]                       m_tdata,  // [0] query_true, [6:1] flags_now,
	                                                    // [8:7] phase_now, [15:9] zero
	// Configuration writes.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [kdhr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [kdhr_pkg::TIME_W-1:0]       cfg_data
);

	logic                            valid_s1;
	logic                            action_s1;
	logic                            key_level_s1;
	logic [kdhr_pkg::FLAG_W-1:0]     query_mask_s1;
	logic                            valid_s2;
	logic                            query_true_s2;
	logic [kdhr_pkg::FLAG_W-1:0]     flags_s2;
	kdhr_pkg::phase_t                phase_s2;
	kdhr_pkg::key_state_t            state_q;
	kdhr_pkg::key_state_t            state_nxt;
	kdhr_pkg::key_cfg_t              cfg_q;
	logic                            query_true_nxt;
	logic                            advance;

	// The result stage moves when it is empty or its transfer completes.
	assign advance   = !valid_s2 || m_tready;
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Configuration registers; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_step   <= kdhr_pkg::RST_TICK_STEP;
			cfg_q.ensure_time <= kdhr_pkg::RST_ENSURE_TIME;
			cfg_q.hold_time   <= kdhr_pkg::RST_HOLD_TIME;
			cfg_q.repeat_time <= kdhr_pkg::RST_REPEAT_TIME;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				kdhr_pkg::CFG_TICK_STEP:   cfg_q.tick_step   <= cfg_data[kdhr_pkg::STEP_W-1:0];
				kdhr_pkg::CFG_ENSURE_TIME: cfg_q.ensure_time <= cfg_data;
				kdhr_pkg::CFG_HOLD_TIME:   cfg_q.hold_time   <= cfg_data;
				kdhr_pkg::CFG_REPEAT_TIME: cfg_q.repeat_time <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1     <= s_tuser;
			key_level_s1  <= s_tdata[0];
			query_mask_s1 <= s_tdata[6:1];
		end
	end

	// Per-item update of the key state.
	kdhr_step u_step (
		.cur        (state_q),
		.cfg        (cfg_q),
		.action     (action_s1),
		.key_level  (key_level_s1),
		.query_mask (query_mask_s1),
		.nxt        (state_nxt),
		.query_true (query_true_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase   <= kdhr_pkg::PH_RELEASED;
			state_q.elapsed <= '0;
			state_q.flags   <= '0;
		end else if (advance && valid_s1) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			query_true_s2 <= query_true_nxt;
			flags_s2      <= state_nxt.flags;
			phase_s2      <= state_nxt.phase;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'b0, phase_s2, flags_s2, query_true_s2};

endmodule

/* tb/sv/testbench.sv */
module testbench;
	import kdhr_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int ELAPSED_CAP = 131071;

	// One result transfer as the predictor sees it.
	typedef struct {
		logic         hit;
		logic [5:0]   flags;
		phase_t       ph;
	} key_result_t;

	// Key qualifier predictor and the store of results still to come.
	class key_event_scoreboard;
		phase_t                ph;
		logic [ELAPSED_W-1:0]  elapsed;
		logic [FLAG_W-1:0]     flags;
		logic [STEP_W-1:0]     step;
		logic [TIME_W-1:0]     ensure;
		logic [TIME_W-1:0]     hold;
		logic [TIME_W-1:0]     rep;
		key_result_t           pending_results[$];
		int                    mismatches;

		function new();
			ph = PH_RELEASED;
			elapsed = '0;
			flags = '0;
			step = RST_TICK_STEP;
			ensure = RST_ENSURE_TIME;
			hold = RST_HOLD_TIME;
			rep = RST_REPEAT_TIME;
			mismatches = 0;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void fail(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: %s", msg);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
			case (idx)
				CFG_TICK_STEP:   step = data[STEP_W-1:0];
				CFG_ENSURE_TIME: ensure = data;
				CFG_HOLD_TIME:   hold = data;
				CFG_REPEAT_TIME: rep = data;
				default: ;
			endcase
		endfunction

		// The timer saturates rather than wrapping.
		function void advance_timer();
			int t;
			t = int'(elapsed) + int'(step);
			elapsed = (t > ELAPSED_CAP) ? ELAPSED_W'(ELAPSED_CAP) : ELAPSED_W'(t);
		endfunction

		function void key_tick(logic key);
			case (ph)
				PH_RELEASED: begin
					if (key) begin
						elapsed = '0;
						flags = '0;
						ph = PH_PRESS_PEND;
					end
				end
				PH_PRESS_PEND: begin
					advance_timer();
					if (elapsed >= ensure) begin
						if (key) begin
							flags |= FL_PRESS_IN | FL_PRESS;
							ph = PH_PRESSED;
						end else begin
							ph = PH_RELEASED;
						end
					end
				end
				PH_PRESSED: begin
					if (!key) begin
						elapsed = '0;
						ph = PH_RELEASE_PEND;
					end else begin
						advance_timer();
						if (elapsed >= hold) begin
							if ((flags & FL_HOLD_IN) == '0) begin
								flags |= FL_HOLD_IN | FL_HOLD;
							end else if (int'(elapsed) >= int'(hold) + int'(rep)) begin
								elapsed = elapsed - ELAPSED_W'(rep);
								flags |= FL_REPEAT_IN | FL_REPEAT;
							end
						end
					end
				end
				default: begin
					advance_timer();
					if (elapsed >= ensure) begin
						if (!key) begin
							ph = PH_RELEASED;
							flags &= ~FL_INSIDE;
						end else begin
							ph = PH_PRESSED;
						end
					end
				end
			endcase
		endfunction

		// Called for every accepted input transfer.
		function void predict_item(logic act, logic key, logic [5:0] mask);
			key_result_t r;
			r.hit = 1'b0;
			if (act == ACT_QUERY) begin
				r.hit = ((flags & mask) == mask);
				flags &= ~(mask & ~FL_INSIDE);
			end else begin
				key_tick(key);
			end
			r.flags = flags;
			r.ph = ph;
			pending_results.push_back(r);
		endfunction

		// Called for every accepted result transfer.
		function void compare_result(logic [15:0] d);
			key_result_t e;
			if (pending_results.size() == 0) begin
				fail($sformatf("unexpected result %h", d));
				return;
			end
			e = pending_results.pop_front();
			if (d[0] !== e.hit)
				fail($sformatf("query_true exp %0d got %0d", e.hit, d[0]));
			if (d[6:1] !== e.flags)
				fail($sformatf("flags_now exp %h got %h", e.flags, d[6:1]));
			if (d[8:7] !== e.ph)
				fail($sformatf("phase_now exp %0d got %0d", e.ph, d[8:7]));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [15:0]           m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [TIME_W-1:0]     cfg_data = '0;

	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int cycles = 0;

	key_event_scoreboard sb = new();

	key_debounce_hold_repeat_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver back-pressure.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.compare_result(m_tdata);
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// One input transfer, preceded by random sender gaps.
	task automatic send_item(logic act, logic key, logic [5:0] mask);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {1'b0, mask, key};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.predict_item(act, key, mask);
	endtask

	// Sender pauses until every expected result has come.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// Register writes only once the block has gone quiet. The upper bits of
	// the step write are junk, and a write to an unused index is ignored.
	task automatic configure(int step, int ensure, int hold, int rep);
		drain();
		repeat (4) @(posedge clk);
		write_reg(CFG_TICK_STEP, {7'($urandom_range(127)), 8'(step)});
		write_reg(CFG_ENSURE_TIME, TIME_W'(ensure));
		write_reg(CFG_HOLD_TIME, TIME_W'(hold));
		write_reg(CFG_REPEAT_TIME, TIME_W'(rep));
		write_reg(CFG_IDX_W'($urandom_range(255, 4)), TIME_W'($urandom));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Runs of constant key level with queries mixed in.
	task automatic run_phase(int step, int ensure, int hold, int rep, int items,
			int run_lo, int run_hi, int query_pct, bit held,
			int src_idle, int snk_stall, int pause_at);
		int sent;
		int len;
		logic lvl;
		logic [5:0] mask;
		bit paused;
		configure(step, ensure, hold, rep);
		src_idle_pct = src_idle;
		snk_stall_pct = snk_stall;
		sent = 0;
		paused = 1'b0;
		while (sent < items) begin
			lvl = held ? 1'b1 : 1'($urandom_range(1));
			len = $urandom_range(run_hi, run_lo);
			for (int j = 0; j < len && sent < items; j++) begin
				if ($urandom_range(99) < query_pct) begin
					mask = $urandom_range(1) ? 6'($urandom_range(63))
					                         : 6'(1 << $urandom_range(5));
					send_item(ACT_QUERY, 1'($urandom_range(1)), mask);
					sent++;
				end
				send_item(ACT_TICK, lvl, 6'($urandom_range(63)));
				sent++;
				// A query may step the count past the pause point, so test a range.
				if (!paused && pause_at != 0 && sent >= pause_at) begin
					drain();
					paused = 1'b1;
				end
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk through bounce, press, hold, repeat and release.
		configure(10, 20, 40, 30);
		send_item(ACT_QUERY, 1'b1, 6'h00);
		send_item(ACT_TICK, 1'b0, 6'h3F);
		send_item(ACT_TICK, 1'b1, 6'h00);
		send_item(ACT_TICK, 1'b0, 6'h00);
		send_item(ACT_TICK, 1'b0, 6'h00);
		send_item(ACT_TICK, 1'b1, 6'h00);
		send_item(ACT_TICK, 1'b1, 6'h00);
		send_item(ACT_TICK, 1'b1, 6'h00);
		send_item(ACT_QUERY, 1'b0, FL_PRESS);
		send_item(ACT_QUERY, 1'b0, FL_PRESS);
		send_item(ACT_TICK, 1'b1, 6'h00);
		send_item(ACT_TICK, 1'b1, 6'h00);
		send_item(ACT_TICK, 1'b1, 6'h00);
		send_item(ACT_TICK, 1'b1, 6'h00);
		send_item(ACT_TICK, 1'b1, 6'h00);
		send_item(ACT_QUERY, 1'b0, FL_HOLD_IN | FL_REPEAT);
		send_item(ACT_QUERY, 1'b1, FL_INSIDE);
		send_item(ACT_TICK, 1'b0, 6'h00);
		send_item(ACT_TICK, 1'b1, 6'h00);
		send_item(ACT_TICK, 1'b1, 6'h00);
		send_item(ACT_TICK, 1'b0, 6'h00);
		send_item(ACT_TICK, 1'b0, 6'h00);
		send_item(ACT_TICK, 1'b0, 6'h00);
		send_item(ACT_TICK, 1'b1, 6'h00);
		send_item(ACT_QUERY, 1'b0, 6'h3F);

		// Long press with a big step and a tiny period drives the timer into
		// saturation.
		run_phase(255, 1, 1, 1, 580, 600, 600, 8, 1'b1, 0, 0, 0);
		run_phase(10, 20, 60, 30, 120, 1, 12, 20, 1'b0, 84, 0, 60);
		// A zero step keeps the timer from advancing; only a phase change that clears it moves it.
		run_phase(0, 32767, 32767, 32767, 30, 1, 10, 25, 1'b0, 0, 84, 0);
		run_phase(255, 2000, 3000, 500, 150, 1, 30, 15, 1'b0, 23, 23, 0);
		run_phase(255, 32767, 32767, 32767, 100, 100, 200, 5, 1'b0, 0, 0, 0);

		drain();
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
